### design/custom_alphabet_sort_checker_core_macros.svh
// Assertion macros for the checker file of the sort checker.
`ifndef CUSTOM_ALPHABET_SORT_CHECKER_CORE_MACROS_SVH
`define CUSTOM_ALPHABET_SORT_CHECKER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/csc_pkg.sv
`default_nettype none

package csc_pkg;

	localparam int unsigned RankW = 5;
	localparam int unsigned CfgAddrW = 5;
	localparam int unsigned CfgDataW = 64;
	localparam int unsigned QueueDepth = 2;

	localparam logic [4:0] NumLetters = 5'd26;
	localparam logic [RankW-1:0] RankOutOfRange = 5'd31;

	// Register indexes, taken from paddr[4:3].
	localparam logic [1:0] RegRanksAtoI = 2'd0;
	localparam logic [1:0] RegRanksJtoR = 2'd1;
	localparam logic [1:0] RegRanksStoZ = 2'd2;

	localparam logic [44:0] RanksAtoIReset = 45'd9043225708576;
	localparam logic [44:0] RanksJtoRReset = 45'd19258043411785;
	localparam logic [39:0] RanksStoZReset = 40'd885558792818;

	// Packed so that letter k sits at bits 5k+4..5k of the whole struct.
	typedef struct packed {
		logic [39:0] s_to_z;
		logic [44:0] j_to_r;
		logic [44:0] a_to_i;
	} ranks_t;

	// What the front end decided about one accepted word.
	typedef struct packed {
		logic [RankW-1:0] rank;
		logic             stored;
		logic             in_prev;
		logic             ovf_evt;
		logic             prefix_short;
		logic             first_word;
		logic             word_end;
		logic             list_start;
	} entry_t;

	typedef struct packed {
		logic [RankW-1:0] prev_rank;
		entry_t           info;
	} item_t;

	function automatic logic [RankW-1:0] rank_lookup(ranks_t ranks, logic [4:0] letter);
		logic [129:0]     tbl;
		logic [7:0]       base;
		logic [RankW-1:0] r;
		tbl = ranks;
		base = 8'(letter) * 8'd5;
		if (letter < NumLetters) begin
			r = tbl[base +: RankW];
		end else begin
			r = RankOutOfRange;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/csc_regs.sv
`default_nettype none

module csc_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [csc_pkg::CfgAddrW-1:0]  paddr,
	input  wire logic [csc_pkg::CfgDataW-1:0]  pwdata,
	output logic      [csc_pkg::CfgDataW-1:0]  prdata,
	output logic                               pready,
	output csc_pkg::ranks_t                    ranks
);

	logic [44:0] a_to_i_q;
	logic [44:0] j_to_r_q;
	logic [39:0] s_to_z_q;
	logic [1:0]  reg_idx;
	logic        wr_en;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_to_i_q <= csc_pkg::RanksAtoIReset;
			j_to_r_q <= csc_pkg::RanksJtoRReset;
			s_to_z_q <= csc_pkg::RanksStoZReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				csc_pkg::RegRanksAtoI: a_to_i_q <= pwdata[44:0];
				csc_pkg::RegRanksJtoR: j_to_r_q <= pwdata[44:0];
				csc_pkg::RegRanksStoZ: s_to_z_q <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			csc_pkg::RegRanksAtoI: prdata = 64'(a_to_i_q);
			csc_pkg::RegRanksJtoR: prdata = 64'(j_to_r_q);
			csc_pkg::RegRanksStoZ: prdata = 64'(s_to_z_q);
			default: prdata = '0;
		endcase
	end

	assign ranks = '{s_to_z: s_to_z_q, j_to_r: j_to_r_q, a_to_i: a_to_i_q};

endmodule

`default_nettype wire

### design/csc_front.sv
`default_nettype none

module csc_front #(
	parameter int unsigned MAX_WORD_LEN = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire logic [4:0]      letter,
	input  wire logic            has_letter,
	input  wire logic            word_end,
	input  wire logic            list_start,
	input  wire csc_pkg::ranks_t ranks,
	output logic                 push,
	input  wire logic            q_full,
	output csc_pkg::item_t       push_item
);

	localparam int unsigned PosW = $clog2(MAX_WORD_LEN + 1);
	localparam int unsigned AddrW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

	logic [csc_pkg::RankW-1:0] rank_mem [MAX_WORD_LEN];

	logic [PosW-1:0]           pos_q;
	logic [PosW-1:0]           prev_len_q;
	logic                      first_q;
	logic                      valid_s1;
	csc_pkg::entry_t           info_s1;
	logic [csc_pkg::RankW-1:0] prev_rank_s1;

	logic                      accept;
	logic [PosW-1:0]           cur_pos;
	logic [PosW-1:0]           next_pos;
	logic                      cur_first;
	logic                      stored;
	logic [AddrW-1:0]          addr;
	logic [csc_pkg::RankW-1:0] rank;

	assign push = valid_s1 & ~q_full;
	assign item_stall = valid_s1 & q_full;
	assign accept = item_valid & ~item_stall;

	// A list start restarts the word before the same word is handled as usual.
	assign cur_pos = list_start ? '0 : pos_q;
	assign cur_first = list_start | first_q;
	assign stored = has_letter && (cur_pos < PosW'(MAX_WORD_LEN));
	assign next_pos = cur_pos + PosW'(stored);
	assign addr = cur_pos[AddrW-1:0];
	assign rank = csc_pkg::rank_lookup(ranks, letter);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			prev_len_q <= '0;
			first_q <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (word_end) begin
					pos_q <= '0;
					prev_len_q <= next_pos;
					first_q <= 1'b0;
				end else begin
					pos_q <= next_pos;
					first_q <= cur_first;
				end
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// The read returns the previous word's rank before this word overwrites it.
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_rank_s1 <= rank_mem[addr];
			if (stored) begin
				rank_mem[addr] <= rank;
			end
			info_s1.rank <= rank;
			info_s1.stored <= stored;
			info_s1.in_prev <= cur_pos < prev_len_q;
			info_s1.ovf_evt <= has_letter & ~stored;
			info_s1.prefix_short <= prev_len_q > next_pos;
			info_s1.first_word <= cur_first;
			info_s1.word_end <= word_end;
			info_s1.list_start <= list_start;
		end
	end

	assign push_item = '{prev_rank: prev_rank_s1, info: info_s1};

endmodule

`default_nettype wire

### design/csc_queue.sv
`default_nettype none

module csc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire csc_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                nonempty,
	output csc_pkg::item_t      head
);

	localparam int unsigned PtrW = $clog2(csc_pkg::QueueDepth);
	localparam int unsigned CntW = $clog2(csc_pkg::QueueDepth + 1);

	csc_pkg::item_t  slot_q [csc_pkg::QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = count_q == CntW'(csc_pkg::QueueDepth);
	assign nonempty = count_q != '0;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

### design/csc_back.sv
`default_nettype none

module csc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           nonempty,
	input  wire csc_pkg::item_t head,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_stall,
	output logic                sorted_so_far,
	output logic                word_overflow
);

	typedef enum logic [1:0] {
		PairUndecided,
		PairInOrder,
		PairViolation
	} pair_t;

	pair_t pair_q;
	logic  sorted_q;
	logic  ovf_q;
	logic  result_valid_q;
	logic  res_sorted_q;
	logic  res_ovf_q;

	pair_t pair_new;
	logic  sorted_new;
	logic  ovf_new;
	logic  can_load;

	// Words that close no word give no result and never wait on the output.
	assign can_load = ~result_valid_q | ~result_stall;
	assign pop = nonempty & (~head.info.word_end | can_load);

	always_comb begin
		pair_new = head.info.list_start ? PairUndecided : pair_q;
		sorted_new = head.info.list_start | sorted_q;
		ovf_new = ~head.info.list_start & ovf_q;
		if (head.info.ovf_evt) begin
			ovf_new = 1'b1;
		end
		if (head.info.stored && !head.info.first_word && pair_new == PairUndecided) begin
			if (!head.info.in_prev) begin
				pair_new = PairInOrder;
			end else if (head.info.rank < head.prev_rank) begin
				pair_new = PairInOrder;
			end else if (head.info.rank > head.prev_rank) begin
				pair_new = PairViolation;
			end
		end
		if (head.info.word_end) begin
			if (!head.info.first_word) begin
				// A longer previous word that starts with this one breaks the order.
				if (pair_new == PairUndecided && head.info.prefix_short) begin
					pair_new = PairViolation;
				end
				if (pair_new == PairViolation) begin
					sorted_new = 1'b0;
				end
			end
			pair_new = PairUndecided;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= PairUndecided;
			sorted_q <= 1'b1;
			ovf_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pair_q <= pair_new;
				sorted_q <= sorted_new;
				ovf_q <= ovf_new;
			end
			if (pop && head.info.word_end) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.info.word_end) begin
			res_sorted_q <= sorted_new;
			res_ovf_q <= ovf_new;
		end
	end

	assign result_valid = result_valid_q;
	assign sorted_so_far = res_sorted_q;
	assign word_overflow = res_ovf_q;

endmodule

`default_nettype wire

### design/custom_alphabet_sort_checker_core.sv
// A word that closes a list word passes the front stage and the queue to the result register.
// Throughput: one word per cycle while the result output is not stalled; the rank memory is
// read once per accepted word and written when it stores a letter. The two-entry queue and
// the front stage let the input run on for three closing words while the output is stalled.
// Reset (arst_n low, asynchronous) clears position, lengths, pair status and overflow, sets the
// sorted flag and loads the identity ranking; the stored previous-word ranks are not cleared.
`default_nettype none

module custom_alphabet_sort_checker_core #(
	parameter int unsigned MAX_WORD_LEN = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [4:0]                    letter,
	input  wire logic                          has_letter,
	input  wire logic                          word_end,
	input  wire logic                          list_start,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               sorted_so_far,
	output logic                               word_overflow,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [csc_pkg::CfgAddrW-1:0]  paddr,
	input  wire logic [csc_pkg::CfgDataW-1:0]  pwdata,
	output logic      [csc_pkg::CfgDataW-1:0]  prdata,
	output logic                               pready
);

	csc_pkg::ranks_t ranks;
	csc_pkg::item_t  push_item;
	csc_pkg::item_t  head;
	logic            push;
	logic            q_full;
	logic            pop;
	logic            nonempty;

	csc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ranks   (ranks)
	);

	csc_front #(
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.letter     (letter),
		.has_letter (has_letter),
		.word_end   (word_end),
		.list_start (list_start),
		.ranks      (ranks),
		.push       (push),
		.q_full     (q_full),
		.push_item  (push_item)
	);

	csc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (nonempty),
		.head      (head)
	);

	csc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.nonempty      (nonempty),
		.head          (head),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.sorted_so_far (sorted_so_far),
		.word_overflow (word_overflow)
	);

endmodule

`default_nettype wire

### design/csc_checker.sv
`default_nettype none
`include "custom_alphabet_sort_checker_core_macros.svh"

module csc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_stall,
	input wire logic result_valid,
	input wire logic result_stall,
	input wire logic sorted_so_far,
	input wire logic word_overflow
);

	// A stalled result keeps its value until it is taken.
	`CSC_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid && $stable(sorted_so_far) && $stable(word_overflow), "stalled result changed")

	// The input only stalls on a word that was taken earlier and is still waiting.
	`CSC_ASSERT_SAME(a_stall_has_cause, clk, arst_n, item_stall, $past(item_stall || (item_valid && !item_stall)), "input stalled with nothing in flight")

	// The queue only fills up while the result output is stalled.
	`CSC_ASSERT_SAME(a_stall_from_output, clk, arst_n, item_stall, $past(result_valid && result_stall), "input stalled without output back-pressure")

endmodule

bind custom_alphabet_sort_checker_core csc_checker u_csc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item_valid),
	.item_stall    (item_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.sorted_so_far (sorted_so_far),
	.word_overflow (word_overflow)
);

`default_nettype wire

### sim/custom_alphabet_sort_checker_core_tb.sv
`timescale 1ns / 100ps

module custom_alphabet_sort_checker_core_tb;

	localparam int MaxLen = 32;
	localparam int QuietLimit = 3000;
	localparam int LongHold = 80;
	localparam int PhaseItems = 22;
	localparam int SettleCycles = 6;

	typedef enum logic [1:0] {
		ORDER_UNDECIDED,
		ORDER_OK,
		ORDER_BAD
	} order_state_t;

	typedef struct packed {
		logic sorted;
		logic ovf;
	} flags_t;

	typedef struct packed {
		logic [4:0] l;
		logic       h;
		logic       we;
		logic       ls;
		logic [5:0] reps;
		logic       typed;
		logic       es;
		logic       eo;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [4:0] letter = '0;
	logic has_letter = 1'b0;
	logic word_end = 1'b0;
	logic list_start = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic sorted_so_far;
	logic word_overflow;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [csc_pkg::CfgAddrW-1:0] paddr = '0;
	logic [csc_pkg::CfgDataW-1:0] pwdata = '0;
	logic [csc_pkg::CfgDataW-1:0] prdata;
	logic pready;

	custom_alphabet_sort_checker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.letter(letter),
		.has_letter(has_letter),
		.word_end(word_end),
		.list_start(list_start),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.sorted_so_far(sorted_so_far),
		.word_overflow(word_overflow),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// Predictor copy of the ranking and of the ordering state.
	logic [44:0] rank_a2i = csc_pkg::RanksAtoIReset;
	logic [44:0] rank_j2r = csc_pkg::RanksJtoRReset;
	logic [39:0] rank_s2z = csc_pkg::RanksStoZReset;
	logic [4:0] prev_rank [MaxLen];
	int prev_len = 0;
	int cur_pos = 0;
	order_state_t pair_state = ORDER_UNDECIDED;
	logic first_of_list = 1'b1;
	logic sorted_seen = 1'b1;
	logic overflow_seen = 1'b0;

	flags_t flags_expected [$];

	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int in_words = 0;
	int results_seen = 0;
	int ovf_results = 0;
	int list_starts = 0;
	int settings_run = 0;

	logic [4:0] gen_prev [40];
	int gen_len = 0;

	plan_row_t plan [19];

	function automatic logic [4:0] letter_rank(logic [4:0] l);
		int idx;
		logic [4:0] r;
		idx = l;
		if (idx < 9) begin
			r = rank_a2i[idx*5 +: 5];
		end else if (idx < 18) begin
			r = rank_j2r[(idx-9)*5 +: 5];
		end else if (l < csc_pkg::NumLetters) begin
			r = rank_s2z[(idx-18)*5 +: 5];
		end else begin
			r = csc_pkg::RankOutOfRange;
		end
		return r;
	endfunction

	function automatic logic [4:0] pick_letter();
		if ($urandom_range(0, 99) < 4) begin
			return 5'($urandom_range(26, 31));
		end
		return 5'($urandom_range(0, 25));
	endfunction

	// kind 0 gives the reversed alphabet, kind 1 random ranks from 0 to 3 with many ties.
	function automatic logic [63:0] ranks_pattern(int first, int count, int kind);
		logic [63:0] v;
		int k;
		v = '0;
		for (k = 0; k < count; k++) begin
			if (kind == 0) begin
				v |= 64'(25 - (first + k)) << (5 * k);
			end else begin
				v |= 64'($urandom_range(0, 3)) << (5 * k);
			end
		end
		return v;
	endfunction

	task automatic step_order_check(input logic [4:0] l, input logic h, input logic we,
			input logic ls, output logic produced, output flags_t res);
		logic [4:0] r;
		produced = 1'b0;
		res = '0;
		if (ls) begin
			sorted_seen = 1'b1;
			overflow_seen = 1'b0;
			first_of_list = 1'b1;
			cur_pos = 0;
			pair_state = ORDER_UNDECIDED;
		end
		if (h) begin
			if (cur_pos >= MaxLen) begin
				overflow_seen = 1'b1;
			end else begin
				r = letter_rank(l);
				if (!first_of_list && pair_state == ORDER_UNDECIDED) begin
					if (cur_pos < prev_len) begin
						if (r < prev_rank[cur_pos]) begin
							pair_state = ORDER_OK;
						end else if (r > prev_rank[cur_pos]) begin
							pair_state = ORDER_BAD;
						end
					end else begin
						pair_state = ORDER_OK;
					end
				end
				prev_rank[cur_pos] = r;
				cur_pos++;
			end
		end
		if (we) begin
			if (!first_of_list) begin
				// A longer previous word that starts with this one breaks the order.
				if (pair_state == ORDER_UNDECIDED && prev_len > cur_pos) begin
					pair_state = ORDER_BAD;
				end
				if (pair_state == ORDER_BAD) begin
					sorted_seen = 1'b0;
				end
			end
			prev_len = cur_pos;
			cur_pos = 0;
			pair_state = ORDER_UNDECIDED;
			first_of_list = 1'b0;
			res.sorted = sorted_seen;
			res.ovf = overflow_seen;
			produced = 1'b1;
		end
	endtask

	task automatic offer_item(input logic [4:0] l, input logic h, input logic we, input logic ls,
			input logic typed, input flags_t typed_flags);
		logic produced;
		flags_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		letter <= l;
		has_letter <= h;
		word_end <= we;
		list_start <= ls;
		if (ls) begin
			list_starts++;
		end
		step_order_check(l, h, we, ls, produced, res);
		if (produced) begin
			flags_expected.push_back(typed ? typed_flags : res);
		end
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		item_valid <= 1'b0;
		while (flags_expected.size() != 0) begin
			@(posedge clk);
		end
		// Items without a word end may still be in flight.
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
		logic [63:0] stored;
		case (idx)
			csc_pkg::RegRanksAtoI: begin
				rank_a2i = value[44:0];
				stored = {19'b0, value[44:0]};
			end
			csc_pkg::RegRanksJtoR: begin
				rank_j2r = value[44:0];
				stored = {19'b0, value[44:0]};
			end
			default: begin
				rank_s2z = value[39:0];
				stored = {24'b0, value[39:0]};
			end
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== stored) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("rank register %0d read back %h, expected %h", idx, prdata, stored);
			end
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed words built from the previous one, so that lists stay sorted
	// for a while; the rest is random noise.
	task automatic gen_words(input int n);
		int sent, len, keep, k, t;
		logic [4:0] word [40];
		logic [4:0] c;
		logic ls, end_sep, want_low, found, nh, nw;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 8) begin
				nh = 1'($urandom_range(0, 1));
				nw = 1'($urandom_range(0, 1));
				offer_item(5'($urandom_range(0, 31)), nh, nw, $urandom_range(0, 15) == 0,
					1'b0, '0);
				if (nh || nw) begin
					sent++;
				end
			end else begin
				ls = ($urandom_range(0, 9) == 0);
				want_low = ($urandom_range(0, 99) < 75);
				if ($urandom_range(0, 99) < 12) begin
					len = gen_len;
					keep = len;
				end else begin
					len = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 36) :
						$urandom_range(0, 6);
					keep = (ls || $urandom_range(0, 99) < 35) ? 0 :
						$urandom_range(0, (len < gen_len) ? len : gen_len);
				end
				for (k = 0; k < len; k++) begin
					if (k < keep && k < gen_len) begin
						word[k] = gen_prev[k];
					end else if (k == keep && k < gen_len && want_low) begin
						found = 1'b0;
						c = pick_letter();
						for (t = 0; t < 8 && !found; t++) begin
							c = pick_letter();
							found = (letter_rank(c) < letter_rank(gen_prev[k]));
						end
						word[k] = c;
					end else begin
						word[k] = pick_letter();
					end
				end
				end_sep = (len == 0) || ($urandom_range(0, 1) == 1);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 19) == 0) begin
						offer_item(pick_letter(), 1'b0, 1'b0, 1'b0, 1'b0, '0);
					end
					offer_item(word[k], 1'b1, !end_sep && k == len - 1, ls && k == 0, 1'b0, '0);
					sent++;
				end
				if (end_sep) begin
					offer_item(pick_letter(), 1'b0, 1'b1, ls && len == 0, 1'b0, '0);
					sent++;
				end
				for (k = 0; k < len; k++) begin
					gen_prev[k] = word[k];
				end
				gen_len = len;
			end
		end
	endtask

	// Receiver side: random stalls, plus a long hold counted here on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= LongHold;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		flags_t exp_flags;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (item_valid && !item_stall) begin
				in_words++;
				moved = 1'b1;
			end
			if (result_valid && !result_stall) begin
				moved = 1'b1;
				results_seen++;
				if (word_overflow) begin
					ovf_results++;
				end
				if (flags_expected.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result word: sorted=%0b overflow=%0b",
							sorted_so_far, word_overflow);
					end
				end else begin
					exp_flags = flags_expected.pop_front();
					if (sorted_so_far !== exp_flags.sorted || word_overflow !== exp_flags.ovf) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result %0d: sorted=%0b overflow=%0b, expected %0b %0b",
								results_seen, sorted_so_far, word_overflow,
								exp_flags.sorted, exp_flags.ovf);
						end
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("no progress for %0d cycles", QuietLimit);
				$display("custom_alphabet_sort_checker_core test failed");
				$finish;
			end
		end
	end

	initial begin : main
		int i, k, s, m;
		plan = '{
			'{5'd1,  1'b1, 1'b0, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd0,  1'b0, 1'b1, 1'b0, 6'd1,  1'b1, 1'b1, 1'b0},
			'{5'd1,  1'b1, 1'b0, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd0,  1'b1, 1'b1, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd1,  1'b1, 1'b1, 1'b0, 6'd1,  1'b1, 1'b0, 1'b0},
			'{5'd0,  1'b0, 1'b0, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd25, 1'b1, 1'b1, 1'b1, 6'd1,  1'b1, 1'b1, 1'b0},
			'{5'd31, 1'b1, 1'b1, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd0,  1'b0, 1'b1, 1'b1, 6'd1,  1'b1, 1'b1, 1'b0},
			'{5'd0,  1'b0, 1'b1, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd30, 1'b1, 1'b0, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd3,  1'b1, 1'b0, 1'b0, 6'd32, 1'b0, 1'b0, 1'b0},
			'{5'd0,  1'b0, 1'b1, 1'b0, 6'd1,  1'b1, 1'b1, 1'b1},
			'{5'd30, 1'b1, 1'b1, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd0,  1'b1, 1'b1, 1'b1, 6'd1,  1'b1, 1'b1, 1'b0},
			'{5'd16, 1'b1, 1'b0, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd4,  1'b1, 1'b1, 1'b0, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd0,  1'b0, 1'b0, 1'b1, 6'd1,  1'b0, 1'b0, 1'b0},
			'{5'd5,  1'b1, 1'b1, 1'b0, 6'd1,  1'b1, 1'b1, 1'b0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (i = 0; i < 19; i++) begin
			for (k = 0; k < plan[i].reps; k++) begin
				offer_item(plan[i].l, plan[i].h, plan[i].we, plan[i].ls, plan[i].typed,
					'{sorted: plan[i].es, ovf: plan[i].eo});
			end
		end
		wait_results_done();

		for (s = 0; s < 6; s++) begin
			case (s)
				1: begin
					cfg_write(csc_pkg::RegRanksAtoI, 64'd0);
					cfg_write(csc_pkg::RegRanksJtoR, 64'd0);
					cfg_write(csc_pkg::RegRanksStoZ, 64'd0);
				end
				2: begin
					cfg_write(csc_pkg::RegRanksAtoI, {64{1'b1}});
					cfg_write(csc_pkg::RegRanksJtoR, {64{1'b1}});
					cfg_write(csc_pkg::RegRanksStoZ, {64{1'b1}});
				end
				3: begin
					cfg_write(csc_pkg::RegRanksAtoI, ranks_pattern(0, 9, 0));
					cfg_write(csc_pkg::RegRanksJtoR, ranks_pattern(9, 9, 0));
					cfg_write(csc_pkg::RegRanksStoZ, ranks_pattern(18, 8, 0));
				end
				4: begin
					cfg_write(csc_pkg::RegRanksAtoI, {$urandom, $urandom});
					cfg_write(csc_pkg::RegRanksJtoR, {$urandom, $urandom});
					cfg_write(csc_pkg::RegRanksStoZ, {$urandom, $urandom});
				end
				5: begin
					cfg_write(csc_pkg::RegRanksAtoI, ranks_pattern(0, 9, 1));
					cfg_write(csc_pkg::RegRanksJtoR, ranks_pattern(9, 9, 1));
					cfg_write(csc_pkg::RegRanksStoZ, ranks_pattern(18, 8, 1));
				end
				default: begin
				end
			endcase
			settings_run++;
			for (m = 0; m < 4; m++) begin
				send_idle_pct = (m == 1) ? 56 : (m == 3) ? 11 : 0;
				rcv_stall_pct = (m == 2) ? 56 : (m == 3) ? 11 : 0;
				gen_words(PhaseItems);
				if (s == 0 && m == 0) begin
					// Hold the result side off while single-letter words keep coming in.
					hold_reqs <= hold_reqs + 1;
					for (k = 0; k < 20; k++) begin
						offer_item(pick_letter(), 1'b1, 1'b1, 1'b0, 1'b0, '0);
					end
				end
				wait_results_done();
			end
		end

		repeat (10) @(posedge clk);
		if (flags_expected.size() != 0) begin
			fail_count++;
		end
		$display("Accepted %0d input words and checked %0d result words (%0d with overflow).",
			in_words, results_seen, ovf_results);
		$display("Covered %0d rank settings, %0d list starts and four idling patterns.",
			settings_run, list_starts);
		if (fail_count == 0) begin
			$display("custom_alphabet_sort_checker_core test passed");
		end else begin
			$display("custom_alphabet_sort_checker_core test failed");
		end
		$finish;
	end

endmodule
